// File: hdl/gdfw_pkg.sv
// ---------------------------------------------------------------------------
// gdfw_pkg - shared definitions for the depth-first graph walker
// Opcode codes and fixed field widths used by the walker core.
// ---------------------------------------------------------------------------
package gdfw_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD_EDGE = 2'd1,
    OP_TRAVERSE = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  localparam int NODE_W     = 6;   // width of vertex fields on the ports
  localparam int CFG_W      = 7;   // width of the vertex count register
  localparam int RESULT_MAX = 64;  // most vertices reported per traversal
  localparam int COUNT_W    = 7;   // holds 0..RESULT_MAX
  localparam int S_DATA_W   = 24;  // edge_from, edge_to, start_node
  localparam int S_USER_W   = 2;   // opcode
  localparam int M_DATA_W   = 8;   // visit_node

endpackage

// File: hdl/gdfw_ram.sv
// ---------------------------------------------------------------------------
// gdfw_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module gdfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/graph_depth_first_walker_core.sv
// ---------------------------------------------------------------------------
// graph_depth_first_walker_core - depth-first walk over an adjacency list
// Holds an undirected graph as linked neighbor lists and walks it on demand.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries commands: clear graph, add undirected edge, traverse from a
//   start vertex; s_tuser holds the opcode. s_tready is high only while the
//   sequencer is idle.
//   m_* returns one transfer per newly visited vertex, in depth-first order;
//   m_tlast marks the final vertex of a traversal.
//   cfg_we/cfg_wdata set the vertex count; write only while idle.
// Sequence:
//   Clear completes in the idle state. Add edge does two head reads and two
//   list writes (S_ADD_RD1, S_ADD_WR1, S_ADD_RD2, S_ADD_WR2). Traverse first
//   sweeps the visited-mark RAM over all MAX_VERTICES entries, then walks
//   each neighbor entry through S_LOOP, S_ENT and S_VIS, adding S_PUSH when
//   the entry opens a new vertex, and pops the stack through S_LOOP and S_POP;
//   the entry RAM read is followed by the visited-mark read.
// Reset:
//   Empties all lists, clears the entry count and sets the vertex count to
//   64. No clearing pass is needed; visited marks are swept per traversal.
// Stall:
//   A single output register holds the next result; the walk pauses while
//   it is full and m_tready is low, and one more vertex is held pending so
//   that the last flag is known before it goes out.
// ---------------------------------------------------------------------------
module graph_depth_first_walker_core #(
  parameter int MAX_VERTICES     = 64,
  parameter int MAX_LIST_ENTRIES = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  // tdata: edge_from[5:0], edge_to[11:6], start_node[17:12]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [gdfw_pkg::S_DATA_W-1:0]  s_tdata,
  // tuser: opcode[1:0]
  input  logic [gdfw_pkg::S_USER_W-1:0]  s_tuser,
  // tdata: visit_node[5:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [gdfw_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [gdfw_pkg::CFG_W-1:0]     cfg_wdata
);

  import gdfw_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);          // vertex index
  localparam int EW  = $clog2(MAX_LIST_ENTRIES);      // entry index
  localparam int EUW = $clog2(MAX_LIST_ENTRIES + 1);  // entry count
  localparam int DW  = $clog2(MAX_VERTICES + 1);      // stack depth
  localparam int ENT_W = VW + EW + 1;                 // vertex, next, next valid
  localparam int CUR_W = EW + 1;                      // cursor: pos, valid

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_RD1, S_ADD_WR1, S_ADD_RD2, S_ADD_WR2,
    S_CLR, S_START, S_LOAD, S_LOOP, S_POP, S_ENT, S_VIS, S_PUSH, S_FINISH
  } state_t;

  state_t state;

  // Input field unpack
  opcode_t            in_op;
  logic [NODE_W-1:0]  in_from, in_to, in_start;
  assign in_op    = opcode_t'(s_tuser[1:0]);
  assign in_from  = s_tdata[5:0];
  assign in_to    = s_tdata[11:6];
  assign in_start = s_tdata[17:12];

  // Architectural state
  logic [CFG_W-1:0]        num_vertices;
  logic [MAX_VERTICES-1:0] head_valid;
  logic [EUW-1:0]          entries_used;

  // Sequencer working registers
  logic [VW-1:0]      a_from, a_to;
  logic [VW-1:0]      w_node;
  logic [VW-1:0]      nb;
  logic [EW-1:0]      top_pos;
  logic               top_valid;
  logic [DW-1:0]      depth;
  logic [COUNT_W-1:0] count;
  logic [VW-1:0]      pending;
  logic               have_pending;
  logic [VW-1:0]      sweep;

  // RAM ports
  logic              head_we;
  logic [VW-1:0]     head_waddr, head_raddr;
  logic [EW-1:0]     head_wdata, head_rdata;
  logic              ent_we;
  logic [EW-1:0]     ent_waddr, ent_raddr;
  logic [ENT_W-1:0]  ent_wdata, ent_rdata;
  logic              vis_we;
  logic [VW-1:0]     vis_waddr, vis_raddr;
  logic              vis_wdata, vis_rdata;
  logic              stk_we;
  logic [VW-1:0]     stk_waddr, stk_raddr;
  logic [CUR_W-1:0]  stk_wdata, stk_rdata;

  // Entry RAM fields
  logic [VW-1:0] ent_vertex;
  logic [EW-1:0] ent_next;
  logic          ent_next_valid;
  assign ent_vertex     = ent_rdata[ENT_W-1 -: VW];
  assign ent_next       = ent_rdata[EW:1];
  assign ent_next_valid = ent_rdata[0];

  // Range checks against min(num_vertices, MAX_VERTICES)
  function automatic logic in_range(input logic [NODE_W-1:0] v,
                                    input logic [CFG_W-1:0] lim);
    in_range = (32'(v) < 32'(lim)) && (32'(v) < 32'(MAX_VERTICES));
  endfunction

  logic edge_ok, start_ok, room_ok;
  assign edge_ok  = in_range(in_from, num_vertices) && in_range(in_to, num_vertices);
  assign start_ok = in_range(in_start, num_vertices);
  assign room_ok  = (32'(entries_used) + 32'd2) <= 32'(MAX_LIST_ENTRIES);

  // Output side handshake helpers
  logic can_emit, need_out, vis_go, out_load;
  assign can_emit = !m_tvalid || m_tready;
  assign need_out = (32'(count) < 32'(RESULT_MAX)) && have_pending;
  assign vis_go   = (state == S_VIS) && !vis_rdata && (!need_out || can_emit);
  // the output register takes a new vertex this cycle
  assign out_load = (vis_go && need_out) || ((state == S_FINISH) && can_emit);

  assign s_tready = (state == S_IDLE);

  // RAM address and write steering
  always_comb begin
    head_we    = 1'b0;
    head_waddr = a_from;
    head_wdata = entries_used[EW-1:0];
    head_raddr = a_from;
    ent_we     = 1'b0;
    ent_waddr  = entries_used[EW-1:0];
    ent_wdata  = {a_to, head_rdata, head_valid[a_from]};
    ent_raddr  = top_pos;
    vis_we     = 1'b0;
    vis_waddr  = sweep;
    vis_wdata  = 1'b0;
    vis_raddr  = nb;
    stk_we     = 1'b0;
    stk_waddr  = VW'(depth - DW'(1));
    stk_wdata  = {top_pos, top_valid};
    stk_raddr  = VW'(depth - DW'(2));
    case (state)
      S_ADD_WR1: begin
        head_we = 1'b1;
        ent_we  = 1'b1;
      end
      S_ADD_RD2: begin
        head_raddr = a_to;
      end
      S_ADD_WR2: begin
        head_raddr = a_to;
        head_we    = 1'b1;
        head_waddr = a_to;
        ent_we     = 1'b1;
        ent_wdata  = {a_from, head_rdata, head_valid[a_to]};
      end
      S_CLR: begin
        vis_we = 1'b1;
      end
      S_START: begin
        vis_we     = 1'b1;
        vis_waddr  = w_node;
        vis_wdata  = 1'b1;
        head_raddr = w_node;
      end
      S_ENT: begin
        vis_raddr = ent_vertex;
      end
      S_VIS: begin
        head_raddr = nb;
        vis_we     = vis_go;
        vis_waddr  = nb;
        vis_wdata  = 1'b1;
        stk_we     = vis_go;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      num_vertices <= CFG_W'(64);
      head_valid   <= '0;
      entries_used <= '0;
      m_tvalid     <= 1'b0;
      have_pending <= 1'b0;
      depth        <= '0;
      count        <= '0;
    end else begin
      if (cfg_we) begin
        num_vertices <= cfg_wdata;
      end
      // drop the result once the receiver takes it
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            a_from <= VW'(in_from);
            a_to   <= VW'(in_to);
            w_node <= VW'(in_start);
            sweep  <= '0;
            case (in_op)
              OP_CLEAR: begin
                head_valid   <= '0;
                entries_used <= '0;
              end
              OP_ADD_EDGE: begin
                if (edge_ok && room_ok) begin
                  state <= S_ADD_RD1;
                end
              end
              OP_TRAVERSE: begin
                if (start_ok) begin
                  state <= S_CLR;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD_RD1: state <= S_ADD_WR1;
        S_ADD_WR1: begin
          head_valid[a_from] <= 1'b1;
          entries_used       <= entries_used + EUW'(1);
          state              <= S_ADD_RD2;
        end
        S_ADD_RD2: state <= S_ADD_WR2;
        S_ADD_WR2: begin
          head_valid[a_to] <= 1'b1;
          entries_used     <= entries_used + EUW'(1);
          state            <= S_IDLE;
        end
        S_CLR: begin
          sweep <= sweep + VW'(1);
          if (32'(sweep) == MAX_VERTICES - 1) begin
            state <= S_START;
          end
        end
        S_START: begin
          pending      <= w_node;
          have_pending <= 1'b1;
          count        <= COUNT_W'(1);
          depth        <= DW'(1);
          state        <= S_LOAD;
        end
        S_LOAD: begin
          top_pos   <= head_rdata;
          top_valid <= head_valid[w_node];
          state     <= S_LOOP;
        end
        S_LOOP: begin
          if (depth == '0) begin
            state <= S_FINISH;
          end else if (!top_valid) begin
            if (depth == DW'(1)) begin
              depth <= '0;
              state <= S_FINISH;
            end else begin
              state <= S_POP;
            end
          end else begin
            state <= S_ENT;
          end
        end
        S_POP: begin
          {top_pos, top_valid} <= stk_rdata;
          depth                <= depth - DW'(1);
          state                <= S_LOOP;
        end
        S_ENT: begin
          // advance the cursor past this entry
          nb        <= ent_vertex;
          top_pos   <= ent_next;
          top_valid <= ent_next_valid;
          state     <= S_VIS;
        end
        S_VIS: begin
          if (vis_rdata) begin
            state <= S_LOOP;
          end else if (vis_go) begin
            if (32'(count) < 32'(RESULT_MAX)) begin
              if (have_pending) begin
                m_tvalid <= 1'b1;
                m_tdata  <= M_DATA_W'(pending);
                m_tlast  <= 1'b0;
              end
              pending      <= nb;
              have_pending <= 1'b1;
              count        <= count + COUNT_W'(1);
            end
            depth <= depth + DW'(1);
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          top_pos   <= head_rdata;
          top_valid <= head_valid[nb];
          state     <= S_LOOP;
        end
        S_FINISH: begin
          if (can_emit) begin
            m_tvalid     <= 1'b1;
            m_tdata      <= M_DATA_W'(pending);
            m_tlast      <= 1'b1;
            have_pending <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  gdfw_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_heads (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  gdfw_ram #(.WIDTH(ENT_W), .DEPTH(MAX_LIST_ENTRIES)) u_entries (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  gdfw_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );

  gdfw_ram #(.WIDTH(CUR_W), .DEPTH(MAX_VERTICES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Checks
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    32'(depth) <= MAX_VERTICES)
    else $error("walk stack deeper than vertex count");

  a_entries_bound: assert property (@(posedge clk) disable iff (rst)
    32'(entries_used) <= MAX_LIST_ENTRIES)
    else $error("entry count beyond entry memory");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !have_pending)
    else $error("pending vertex left after traversal");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && can_emit) |=> (state == S_IDLE && m_tvalid && m_tlast))
    else $error("traversal ended without last result");

endmodule
